FILE: design/amt_pkg.sv
package amt_pkg;

	localparam logic [1:0] REG_BLOCK_SIZE   = 2'd0;
	localparam logic [1:0] REG_OFFSET       = 2'd1;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

	localparam logic [4:0]  RST_BLOCK_SIZE   = 5'd21;
	localparam logic [8:0]  RST_OFFSET       = 9'd10;
	localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
	localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd480;

	localparam int unsigned HEIGHT_CAP = 1024;
	localparam logic [7:0]  PIX_WHITE  = 8'd255;
	localparam logic [7:0]  PIX_BLACK  = 8'd0;

endpackage

FILE: design/amt_if.sv
interface pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	logic       is_flush;
	modport source (output valid, pixel, is_flush, input ready);
	modport sink   (input valid, pixel, is_flush, output ready);
endinterface

interface res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_pixel;
	logic [9:0] out_row;
	logic [9:0] out_col;
	logic       last_of_frame;
	modport source (output valid, out_pixel, out_row, out_col, last_of_frame, input ready);
	modport sink   (input valid, out_pixel, out_row, out_col, last_of_frame, output ready);
endinterface

interface cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [10:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/amt_cell.sv
module amt_cell import amt_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_BLOCK = 31,
	parameter int K         = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_BLOCK)-1:0] wr_slot,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
	input  logic [7:0]                   wr_data,
	input  logic [$clog2(MAX_BLOCK)-1:0] base,
	input  logic [$clog2(MAX_BLOCK+1)-1:0] blk,
	input  logic [$clog2(MAX_BLOCK)-1:0] cslot,
	input  logic                         in_v,
	input  logic [$clog2(MAX_WIDTH)-1:0] in_col,
	input  logic                         in_center,
	input  logic [$clog2(MAX_BLOCK*MAX_BLOCK*255+1)-1:0] in_sum,
	output logic                         out_v,
	output logic [$clog2(MAX_WIDTH)-1:0] out_col,
	output logic                         out_center,
	output logic [$clog2(MAX_BLOCK*MAX_BLOCK*255+1)-1:0] out_sum
);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int SLW = $clog2(MAX_BLOCK);
	localparam int SW  = $clog2(MAX_BLOCK*MAX_BLOCK*255+1);

	logic [7:0]    mem [MAX_WIDTH];
	logic [7:0]    rd_q;
	logic          v_q;
	logic [CW-1:0] col_q;
	logic          cen_q;
	logic [SW-1:0] sum_q;
	logic [SLW:0]  gap;
	logic [SLW:0]  gap_m;
	logic          en;

	always_ff @(posedge clk) begin
		if (wr_en && wr_slot == SLW'(K)) begin
			mem[wr_col] <= wr_data;
		end
		rd_q  <= mem[in_col];
		col_q <= in_col;
		cen_q <= in_center;
		sum_q <= in_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= in_v;
		end
	end

	always_comb begin
		gap   = (SLW+1)'(K + MAX_BLOCK) - {1'b0, base};
		gap_m = (gap >= (SLW+1)'(MAX_BLOCK)) ? gap - (SLW+1)'(MAX_BLOCK) : gap;
		en    = cen_q ? (cslot == SLW'(K)) : ({1'b0, gap_m} < (SLW+2)'(blk));
	end

	assign out_v      = v_q;
	assign out_col    = col_q;
	assign out_center = cen_q;
	assign out_sum    = sum_q + (en ? SW'(rd_q) : SW'(0));

endmodule

FILE: design/adaptive_mean_threshold.sv
// Adaptive mean threshold over a streamed grey frame.
// Pixels enter on the pix channel in raster order; a word with is_flush set
// carries no pixel and only drains one delayed result. Results leave on the
// res channel with their row, column and an end of frame mark. The cfg channel
// writes block_size, offset, image_width and image_height; the user must write
// them only while the block idles, as the block itself does not enforce it.
// A pixel leaves once the pixel half*W + half places after it has been taken,
// or on a flush. For an interior result the window columns are sent one per
// cycle down a chain of MAX_BLOCK row cells, each holding one ring row and
// adding its pixel to the running sum; a border result sends only its centre
// pixel. The result then waits in an output register; no new input is taken
// before it gets there, but the next input is taken while the receiver stalls
// and a stalled full register holds the following one. Reset clears the
// state, positions, counters, output valid and configuration registers to
// their defaults; the row store itself needs no clearing.
module adaptive_mean_threshold import amt_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_BLOCK = 31
) (
	input  logic clk,
	input  logic arst_n,
	pix_if.sink   pix,
	res_if.source res,
	cfg_if.sink   cfg
);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH+1);
	localparam int SLW  = $clog2(MAX_BLOCK);
	localparam int BW   = $clog2(MAX_BLOCK+1);
	localparam int SW   = $clog2(MAX_BLOCK*MAX_BLOCK*255+1);
	localparam int BBW  = $clog2(MAX_BLOCK*MAX_BLOCK+1);
	localparam int DMAX = (MAX_BLOCK/2)*MAX_WIDTH + MAX_BLOCK/2;
	localparam int DW   = $clog2(DMAX+1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ISSUE = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_CALC  = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [4:0]  block_size_q;
	logic [8:0]  offset_q;
	logic [10:0] image_width_q;
	logic [10:0] image_height_q;

	logic [2:0]     st_q;
	logic [CW-1:0]  in_col_q;
	logic [9:0]     in_row_q;
	logic [SLW-1:0] in_slot_q;
	logic [CW-1:0]  out_col_q;
	logic [9:0]     out_row_q;
	logic [SLW-1:0] out_slot_q;
	logic [DW-1:0]  pend_q;
	logic [BW-1:0]  tok_q;
	logic           intr_q;
	logic [SLW-1:0] base_q;
	logic [BBW-1:0] bb_q;
	logic [SW-1:0]  acc_q;
	logic [7:0]     px_q;
	logic [10+BBW-1:0] prod_q;
	logic           tpos_q;

	logic       ov_q;
	logic [7:0] opix_q;
	logic [9:0] orow_q;
	logic [9:0] ocol_q;
	logic       olast_q;
	logic       ointr_q;

	logic [WW-1:0]  w_eff;
	logic [10:0]    h_eff;
	logic [BW-1:0]  b_eff;
	logic [BW-1:0]  half;
	logic [DW-1:0]  delay;
	logic           interior;
	logic [SLW-1:0] base_c;
	logic           acc_in;
	logic           emit;
	logic           load_out;
	logic signed [10:0] t;

	logic           chain_v   [MAX_BLOCK+1];
	logic [CW-1:0]  chain_col [MAX_BLOCK+1];
	logic           chain_cen [MAX_BLOCK+1];
	logic [SW-1:0]  chain_sum [MAX_BLOCK+1];

	always_comb begin
		int unsigned wv, hv, bv, hf, bs;
		wv = image_width_q;
		if (wv < 1) wv = 1;
		if (wv > MAX_WIDTH) wv = MAX_WIDTH;
		hv = image_height_q;
		if (hv < 1) hv = 1;
		if (hv > HEIGHT_CAP) hv = HEIGHT_CAP;
		bv = block_size_q;
		if (bv < 3) bv = 3;
		if (bv > MAX_BLOCK) bv = MAX_BLOCK;
		if (bv % 2 == 0) bv = bv - 1;
		hf    = bv / 2;
		w_eff = WW'(wv);
		h_eff = 11'(hv);
		b_eff = BW'(bv);
		half  = BW'(hf);
		delay = DW'(hf * wv + hf);
		interior = (32'(out_row_q) >= hf) && (32'(out_row_q) + hf < hv)
			&& (32'(out_col_q) >= hf) && (32'(out_col_q) + hf < wv);
		bs = 32'(out_slot_q) + MAX_BLOCK - hf;
		if (bs >= MAX_BLOCK) bs = bs - MAX_BLOCK;
		base_c = SLW'(bs);
	end

	assign cfg.ready = 1'b1;
	assign pix.ready = (st_q == S_IDLE);
	assign acc_in    = pix.valid && pix.ready;
	assign emit      = pix.is_flush ? (pend_q != '0) : (pend_q >= delay);
	assign load_out  = (st_q == S_FIN) && (!ov_q || res.ready);
	assign t         = $signed({3'b000, px_q}) + $signed({{2{offset_q[8]}}, offset_q}) + 11'sd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q   <= RST_BLOCK_SIZE;
			offset_q       <= RST_OFFSET;
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BLOCK_SIZE:   block_size_q   <= cfg.data[4:0];
				REG_OFFSET:       offset_q       <= cfg.data[8:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg.data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
			tok_q      <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (acc_in) begin
						if (!pix.is_flush) begin
							if ({1'b0, in_col_q} + WW'(1) >= w_eff) begin
								in_col_q  <= '0;
								in_slot_q <= (in_slot_q == SLW'(MAX_BLOCK-1)) ? '0 : in_slot_q + SLW'(1);
								in_row_q  <= ({1'b0, in_row_q} + 11'd1 >= h_eff) ? '0 : in_row_q + 10'd1;
							end else begin
								in_col_q <= in_col_q + CW'(1);
							end
							if (!emit) begin
								pend_q <= pend_q + DW'(1);
							end
						end else if (emit) begin
							pend_q <= pend_q - DW'(1);
						end
						if (emit) begin
							st_q  <= S_ISSUE;
							tok_q <= '0;
						end
					end
				end
				S_ISSUE: begin
					if (intr_q && tok_q < b_eff) begin
						tok_q <= tok_q + BW'(1);
					end else begin
						st_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (chain_v[MAX_BLOCK] && chain_cen[MAX_BLOCK]) begin
						st_q <= S_CALC;
					end
				end
				S_CALC: begin
					st_q <= S_FIN;
				end
				S_FIN: begin
					if (load_out) begin
						st_q <= S_IDLE;
						if ({1'b0, out_col_q} + WW'(1) >= w_eff) begin
							out_col_q  <= '0;
							out_slot_q <= (out_slot_q == SLW'(MAX_BLOCK-1)) ? '0 : out_slot_q + SLW'(1);
							out_row_q  <= ({1'b0, out_row_q} + 11'd1 >= h_eff) ? '0 : out_row_q + 10'd1;
						end else begin
							out_col_q <= out_col_q + CW'(1);
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			intr_q <= interior;
			base_q <= base_c;
			bb_q   <= BBW'(b_eff) * BBW'(b_eff);
			acc_q  <= '0;
		end else if (chain_v[MAX_BLOCK]) begin
			if (chain_cen[MAX_BLOCK]) begin
				px_q <= chain_sum[MAX_BLOCK][7:0];
			end else begin
				acc_q <= acc_q + chain_sum[MAX_BLOCK];
			end
		end
		if (st_q == S_CALC) begin
			tpos_q <= (t > 11'sd0);
			prod_q <= t[9:0] * bb_q;
		end
		if (load_out) begin
			if (intr_q) begin
				opix_q <= (!tpos_q || (10+BBW+SW)'(prod_q) <= (10+BBW+SW)'(acc_q)) ?
					PIX_BLACK : PIX_WHITE;
			end else begin
				opix_q <= px_q;
			end
			orow_q  <= out_row_q;
			ocol_q  <= 10'(out_col_q);
			olast_q <= ({1'b0, out_row_q} == h_eff - 11'd1) &&
				({1'b0, out_col_q} == w_eff - WW'(1));
			ointr_q <= intr_q;
		end
	end

	assign chain_v[0]   = (st_q == S_ISSUE);
	assign chain_cen[0] = !(intr_q && tok_q < b_eff);
	assign chain_col[0] = chain_cen[0] ? out_col_q : out_col_q - CW'(half) + CW'(tok_q);
	assign chain_sum[0] = '0;

	for (genvar k = 0; k < MAX_BLOCK; k++) begin : g_cell
		amt_cell #(
			.MAX_WIDTH(MAX_WIDTH),
			.MAX_BLOCK(MAX_BLOCK),
			.K(k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.wr_en(acc_in && !pix.is_flush),
			.wr_slot(in_slot_q),
			.wr_col(in_col_q),
			.wr_data(pix.pixel),
			.base(base_q),
			.blk(b_eff),
			.cslot(out_slot_q),
			.in_v(chain_v[k]),
			.in_col(chain_col[k]),
			.in_center(chain_cen[k]),
			.in_sum(chain_sum[k]),
			.out_v(chain_v[k+1]),
			.out_col(chain_col[k+1]),
			.out_center(chain_cen[k+1]),
			.out_sum(chain_sum[k+1])
		);
	end

	assign res.valid         = ov_q;
	assign res.out_pixel     = opix_q;
	assign res.out_row       = orow_q;
	assign res.out_col       = ocol_q;
	assign res.last_of_frame = olast_q;

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pend_q) <= DMAX)
		else $error("pending count beyond the longest delay");

	a_chain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		chain_v[MAX_BLOCK] |-> (st_q == S_ISSUE || st_q == S_WAIT))
		else $error("chain word outside a window job");

	a_binary: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && ointr_q) |-> (opix_q == PIX_BLACK || opix_q == PIX_WHITE))
		else $error("interior result not black or white");

endmodule

FILE: verif/adaptive_mean_threshold_tb.sv
`timescale 1ns / 1ps

module adaptive_mean_threshold_tb;
	import amt_pkg::*;

	localparam int MAX_WIDTH = 1024;
	localparam int MAX_BLOCK = 31;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [7:0] pixel;
		logic [9:0] row;
		logic [9:0] col;
		logic       last;
	} thr_word_t;

	typedef struct {
		logic [7:0] pixel;
		logic       is_flush;
		logic       has_exp;
		thr_word_t  exp;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pix_if pix();
	res_if res();
	cfg_if cfg();

	adaptive_mean_threshold DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix.sink),
		.res    (res.source),
		.cfg    (cfg.sink)
	);

	always #5 clk = ~clk;

	// Shadow of the block's state.
	logic [7:0]  ring [MAX_BLOCK][MAX_WIDTH];
	int unsigned in_row, in_col, in_slot;
	int unsigned out_row, out_col, out_slot;
	int unsigned backlog;
	logic [4:0]  blk_reg;
	logic [8:0]  ofs_reg;
	logic [10:0] wid_reg;
	logic [10:0] hgt_reg;

	thr_word_t   expected_words [$];
	logic        expected_flag [$];
	thr_word_t   typed_words [$];
	int          errors = 0;
	int          idle_cycles = 0;
	int          src_idle_pct = 0;
	int          snk_idle_pct = 0;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic int unsigned frame_width();
		int unsigned w;
		w = wid_reg;
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned frame_height();
		int unsigned h;
		h = hgt_reg;
		if (h < 1) h = 1;
		if (h > HEIGHT_CAP) h = HEIGHT_CAP;
		return h;
	endfunction

	function automatic int unsigned window_side();
		int unsigned b;
		b = blk_reg;
		if (b < 3) b = 3;
		if (b > MAX_BLOCK) b = MAX_BLOCK;
		if (b % 2 == 0) b--;
		return b;
	endfunction

	task automatic step_pos(inout int unsigned r, inout int unsigned c, inout int unsigned s);
		c++;
		if (c >= frame_width()) begin
			c = 0;
			s = (s + 1) % MAX_BLOCK;
			r++;
			if (r >= frame_height()) r = 0;
		end
	endtask

	// Returns 1 and the thresholded word when the input releases one.
	task automatic threshold_step(input logic [7:0] px_in, input logic flush,
			output logic got, output thr_word_t word);
		int unsigned w, h, b, half, sum, s;
		int lim;
		logic [7:0] px;
		w = frame_width();
		h = frame_height();
		b = window_side();
		half = b / 2;
		got = 1'b0;
		word = '0;
		if (!flush) begin
			ring[in_slot][in_col] = px_in;
			step_pos(in_row, in_col, in_slot);
			backlog++;
			if (backlog <= half * w + half) return;
		end else if (backlog == 0) begin
			return;
		end
		backlog--;
		px = ring[out_slot][out_col];
		word.pixel = px;
		if (out_row >= half && out_row + half < h && out_col >= half && out_col + half < w) begin
			sum = 0;
			for (int i = 0; i < b; i++) begin
				s = (out_slot + MAX_BLOCK - half + i) % MAX_BLOCK;
				for (int j = 0; j < b; j++) sum += ring[s][out_col - half + j];
			end
			lim = int'(sum / (b * b)) - int'($signed(ofs_reg));
			word.pixel = (int'(px) < lim) ? PIX_BLACK : PIX_WHITE;
		end
		word.row = out_row[9:0];
		word.col = out_col[9:0];
		word.last = (out_row == h - 1 && out_col == w - 1);
		got = 1'b1;
		step_pos(out_row, out_col, out_slot);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
		pix.valid <= 1'b0;
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_BLOCK_SIZE:   blk_reg = val[4:0];
			REG_OFFSET:       ofs_reg = val[8:0];
			REG_IMAGE_WIDTH:  wid_reg = val;
			REG_IMAGE_HEIGHT: hgt_reg = val;
			default: ;
		endcase
	endtask

	task automatic send_word(input logic [7:0] px, input logic flush,
			input logic has_exp, input thr_word_t typed);
		logic got;
		thr_word_t word;
		cfg.valid <= 1'b0;
		while ($urandom_range(99) < src_idle_pct) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.pixel <= px;
		pix.is_flush <= flush;
		do @(posedge clk); while (!pix.ready);
		threshold_step(px, flush, got, word);
		if (got) begin
			expected_words = {expected_words, word};
			if (has_exp) typed_words = {typed_words, typed};
			expected_flag = {expected_flag, has_exp};
		end else if (has_exp) begin
			report_mismatch("directed row expected a word the predictor did not release");
		end
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		pix.valid <= 1'b0;
		cfg.valid <= 1'b0;
		while (expected_words.size() != 0 && guard < WATCHDOG_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (3 * MAX_BLOCK + 40) @(posedge clk);
	endtask

	task automatic flush_all();
		while (backlog != 0) send_word(8'($urandom_range(255)), 1'b1, 1'b0, '0);
	endtask

	task automatic random_frame(input int unsigned w, input int unsigned h);
		for (int unsigned k = 0; k < w * h; k++) begin
			if ($urandom_range(99) < 5) send_word(8'($urandom_range(255)), 1'b1, 1'b0, '0);
			case ($urandom_range(3))
				0: send_word($urandom_range(1) ? 8'hFF : 8'h00, 1'b0, 1'b0, '0);
				1: send_word(8'(100 + $urandom_range(40)), 1'b0, 1'b0, '0);
				default: send_word(8'($urandom_range(255)), 1'b0, 1'b0, '0);
			endcase
		end
		flush_all();
	endtask

	// Result side: random stall and in-order compare.
	always @(posedge clk) begin
		thr_word_t got_w, exp_w, typ;
		logic flag;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				got_w = {res.out_pixel, res.out_row, res.out_col, res.last_of_frame};
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h", got_w));
				end else begin
					exp_w = expected_words.pop_front();
					flag = expected_flag.pop_front();
					if (flag) begin
						typ = typed_words.pop_front();
						if (typ !== exp_w) report_mismatch("predictor disagrees with table");
					end
					if (got_w.pixel !== exp_w.pixel)
						report_mismatch($sformatf("out_pixel %0d, want %0d", got_w.pixel, exp_w.pixel));
					if (got_w.row !== exp_w.row)
						report_mismatch($sformatf("out_row %0d, want %0d", got_w.row, exp_w.row));
					if (got_w.col !== exp_w.col)
						report_mismatch($sformatf("out_col %0d, want %0d", got_w.col, exp_w.col));
					if (got_w.last !== exp_w.last)
							report_mismatch($sformatf("last_of_frame %0b, want %0b",
							got_w.last, exp_w.last));
				end
			end
			res.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("adaptive_mean_threshold_tb: errors");
			$finish;
		end
	end

	stim_row_t table_rows [$];

	function automatic stim_row_t mk(input logic [7:0] px, input logic fl,
			input logic he, input thr_word_t e);
		stim_row_t r;
		r.pixel = px;
		r.is_flush = fl;
		r.has_exp = he;
		r.exp = e;
		return r;
	endfunction

	initial begin
		pix.valid = 1'b0;
		pix.pixel = '0;
		pix.is_flush = 1'b0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_BLOCK_SIZE;
		cfg.data = '0;
		for (int i = 0; i < MAX_BLOCK; i++)
			for (int j = 0; j < MAX_WIDTH; j++) ring[i][j] = '0;
		in_row = 0; in_col = 0; in_slot = 0;
		out_row = 0; out_col = 0; out_slot = 0;
		backlog = 0;
		blk_reg = RST_BLOCK_SIZE;
		ofs_reg = RST_OFFSET;
		wid_reg = RST_IMAGE_WIDTH;
		hgt_reg = RST_IMAGE_HEIGHT;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A flush after reset releases nothing; then a 3x3 frame, window 3.
		write_reg(REG_BLOCK_SIZE, 11'd3);
		write_reg(REG_OFFSET, 11'd0);
		write_reg(REG_IMAGE_WIDTH, 11'd3);
		write_reg(REG_IMAGE_HEIGHT, 11'd3);
		table_rows = {
			mk(8'd7, 1'b1, 1'b0, '0),
			mk(8'd255, 1'b0, 1'b0, '0),
			mk(8'd0, 1'b0, 1'b0, '0),
			mk(8'd255, 1'b0, 1'b0, '0),
			mk(8'd0, 1'b0, 1'b0, '0),
			mk(8'd0, 1'b0, 1'b1, '{8'd255, 10'd0, 10'd0, 1'b0}),
			mk(8'd0, 1'b0, 1'b1, '{8'd0, 10'd0, 10'd1, 1'b0}),
			mk(8'd255, 1'b0, 1'b1, '{8'd255, 10'd0, 10'd2, 1'b0}),
			mk(8'd0, 1'b0, 1'b1, '{8'd0, 10'd1, 10'd0, 1'b0}),
			mk(8'd255, 1'b0, 1'b0, '0),
			mk(8'd0, 1'b1, 1'b0, '0),
			mk(8'd0, 1'b1, 1'b0, '0),
			mk(8'd0, 1'b1, 1'b0, '0),
			mk(8'd0, 1'b1, 1'b1, '{8'd255, 10'd2, 10'd2, 1'b1}),
			mk(8'd0, 1'b1, 1'b0, '0)
		};
		foreach (table_rows[i])
			send_word(table_rows[i].pixel, table_rows[i].is_flush,
				table_rows[i].has_exp, table_rows[i].exp);
		wait_drained();

		// Single pixel frame and a one-wide column.
		write_reg(REG_IMAGE_WIDTH, 11'd1);
		write_reg(REG_IMAGE_HEIGHT, 11'd1);
		send_word(8'd200, 1'b0, 1'b0, '0);
		send_word(8'd0, 1'b1, 1'b1, '{8'd200, 10'd0, 10'd0, 1'b1});
		wait_drained();
		write_reg(REG_IMAGE_HEIGHT, 11'd5);
		random_frame(1, 5);
		wait_drained();

		src_idle_pct = 38; snk_idle_pct = 47;
		write_reg(REG_BLOCK_SIZE, 11'd4);
		write_reg(REG_OFFSET, 11'h100);
		write_reg(REG_IMAGE_WIDTH, 11'd12);
		write_reg(REG_IMAGE_HEIGHT, 11'd10);
		random_frame(12, 10);
		wait_drained();

		src_idle_pct = 47; snk_idle_pct = 38;
		write_reg(REG_BLOCK_SIZE, 11'd5);
		write_reg(REG_OFFSET, 11'd255);
		random_frame(12, 10);
		wait_drained();
		write_reg(REG_OFFSET, 11'h1F6);
		random_frame(12, 10);
		wait_drained();

		src_idle_pct = 0; snk_idle_pct = 0;
		write_reg(REG_BLOCK_SIZE, 11'd0);
		write_reg(REG_OFFSET, 11'h101);
		write_reg(REG_IMAGE_WIDTH, 11'd9);
		write_reg(REG_IMAGE_HEIGHT, 11'd7);
		random_frame(9, 7);
		wait_drained();
		// Largest window over a frame too short for any interior pixel.
		write_reg(REG_BLOCK_SIZE, 11'd31);
		write_reg(REG_OFFSET, 11'd3);
		write_reg(REG_IMAGE_WIDTH, 11'd31);
		write_reg(REG_IMAGE_HEIGHT, 11'd2);
		random_frame(31, 2);
		wait_drained();
		// Width clipped above the maximum; a short run of the row is drained.
		write_reg(REG_BLOCK_SIZE, 11'd3);
		write_reg(REG_IMAGE_WIDTH, 11'h7FF);
		write_reg(REG_IMAGE_HEIGHT, 11'd1);
		random_frame(40, 1);
		wait_drained();

		if (errors == 0 && expected_words.size() == 0) begin
			$display("adaptive_mean_threshold_tb: clean");
		end else begin
			$display("adaptive_mean_threshold_tb: errors");
		end
		$finish;
	end

endmodule
